// File: src/ssap_pkg.sv
`timescale 1ns / 1ps

package ssap_pkg;

  // Field widths
  localparam int AMP_W    = 16;
  localparam int PHASE_W  = 32;
  localparam int SAMPLE_W = 16;

  // Sine table geometry
  localparam int SINE_INDEX_BITS = 12;
  localparam int QUARTER_LEN     = (1 << (SINE_INDEX_BITS - 2)) + 1;
  localparam int QADDR_W         = SINE_INDEX_BITS - 1;
  localparam int SINE_W          = 15;   // magnitude only, 0..32767

  // Product and rounding
  localparam int PROD_W    = AMP_W + SINE_W + 1;
  localparam int FRAC_BITS = 15;

  localparam logic [63:0] PI_Q44 = 64'h3243F6A8885A308D >> 16;
  localparam int          ANG_SH = (SINE_INDEX_BITS - 1) + 14;

  typedef logic [SINE_W-1:0] quarter_rom_t [QUARTER_LEN];

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Q30 sine of q quarter-steps, Taylor series to the 21st power
  function automatic logic [31:0] sine_q30(input logic [63:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (PI_Q44 * q + (64'd1 << (ANG_SH - 1))) >> ANG_SH;
    x2   = mul_q30(x, x);
    term = x;
    sum  = x;
    term = mul_q30(term, x2) / 64'd6;   sum = sum - term;
    term = mul_q30(term, x2) / 64'd20;  sum = sum + term;
    term = mul_q30(term, x2) / 64'd42;  sum = sum - term;
    term = mul_q30(term, x2) / 64'd72;  sum = sum + term;
    term = mul_q30(term, x2) / 64'd110; sum = sum - term;
    term = mul_q30(term, x2) / 64'd156; sum = sum + term;
    term = mul_q30(term, x2) / 64'd210; sum = sum - term;
    term = mul_q30(term, x2) / 64'd272; sum = sum + term;
    term = mul_q30(term, x2) / 64'd342; sum = sum - term;
    term = mul_q30(term, x2) / 64'd420; sum = sum + term;
    return sum[31:0];
  endfunction

  function automatic quarter_rom_t build_quarter_wave();
    quarter_rom_t rom;
    logic [63:0]  v;
    for (int q = 0; q < QUARTER_LEN; q++) begin
      v = (64'(sine_q30(64'(q))) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[q] = v[SINE_W-1:0];
    end
    return rom;
  endfunction

endpackage

// File: src/ssap_sine_rom.sv
`timescale 1ns / 1ps

module ssap_sine_rom
  import ssap_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  logic [QADDR_W-1:0] rd_addr,
  output logic [SINE_W-1:0]  rd_data
);

  localparam quarter_rom_t QUARTER_WAVE = build_quarter_wave();

  // synchronous read; addresses above the quarter length never occur
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= QUARTER_WAVE[rd_addr];
    end
  end

endmodule

// File: src/sine_synth_am_pm.sv
`timescale 1ns / 1ps

// Sine oscillator with amplitude and phase modulation. Each input transfer
// carries an amplitude (Q1.15), a 32-bit phase step, a 32-bit phase offset
// and a block-start flag in tuser. With direct_phase_mode at 0 the phase
// accumulator takes the step (or is loaded with the step alone on a block
// start) and the angle is accumulator plus offset; with direct_phase_mode at
// 1 the angle is the offset and the accumulator holds. The output is the
// amplitude times the sine of the angle, rounded half up and saturated to
// Q1.15; the sine comes from a quarter-wave ROM indexed by the top 12 angle
// bits. The block takes one sample per clock while the output is not
// stalled and gives one result per sample, registered through stages A,
// B, C and D; the rate is set by the single-add accumulator feedback in
// the input stage. The four stages hold four samples under backpressure.
// direct_phase_mode is written through the cfg port, which is always
// ready; write it only while the pipe is empty.

module sine_synth_am_pm
  import ssap_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,       // direct_phase_mode

  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [15:0] amplitude, [47:16] phase_step, [79:48] phase_offset
  input  logic [AMP_W+2*PHASE_W-1:0]  s_axis_tdata,
  // [0] block_start
  input  logic                        s_axis_tuser,

  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [15:0] sample_out
  output logic [SAMPLE_W-1:0]         m_axis_tdata
);

  localparam logic [SINE_INDEX_BITS-1:0] QN = SINE_INDEX_BITS'(1 << (SINE_INDEX_BITS - 2));
  localparam logic [SINE_INDEX_BITS-1:0] HN = SINE_INDEX_BITS'(1 << (SINE_INDEX_BITS - 1));
  localparam logic [SINE_INDEX_BITS-1:0] TQN = QN + HN;

  localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1 << (FRAC_BITS - 1));
  localparam logic signed [PROD_W:0] SAT_MAX    = (PROD_W+1)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [PROD_W:0] SAT_MIN    = -((PROD_W+1)'(1 << (SAMPLE_W - 1)));

  // input field slices
  logic signed [AMP_W-1:0]   in_amp;
  logic        [PHASE_W-1:0] in_step;
  logic        [PHASE_W-1:0] in_offset;

  assign in_amp    = s_axis_tdata[AMP_W-1:0];
  assign in_step   = s_axis_tdata[AMP_W +: PHASE_W];
  assign in_offset = s_axis_tdata[AMP_W+PHASE_W +: PHASE_W];

  // config register
  logic direct_phase_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_phase_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      direct_phase_mode <= cfg_data;
    end
  end

  // stage valids and load enables; each stage moves when the next has room
  logic v_a, v_b, v_c;
  logic load_a, load_b, load_c, load_d;
  logic in_xfer;

  assign load_d        = !m_axis_tvalid || m_axis_tready;
  assign load_c        = !v_c || load_d;
  assign load_b        = !v_b || load_c;
  assign load_a        = !v_a || load_b;
  assign s_axis_tready = load_a;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a           <= 1'b0;
      v_b           <= 1'b0;
      v_c           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_a) begin
        v_a <= s_axis_tvalid;
      end
      if (load_b) begin
        v_b <= v_a;
      end
      if (load_c) begin
        v_c <= v_b;
      end
      if (load_d) begin
        m_axis_tvalid <= v_c;
      end
    end
  end

  // stage A: phase accumulator and angle
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] phase_acc_next;
  logic [PHASE_W-1:0] angle;

  always_comb begin
    phase_acc_next = s_axis_tuser ? in_step : phase_acc + in_step;
    angle          = direct_phase_mode ? in_offset : phase_acc_next + in_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (in_xfer && !direct_phase_mode) begin
      phase_acc <= phase_acc_next;
    end
  end

  logic        [SINE_INDEX_BITS-1:0] idx_a;
  logic signed [AMP_W-1:0]           amp_a;

  always_ff @(posedge clk) begin
    if (load_a) begin
      idx_a <= angle[PHASE_W-1 -: SINE_INDEX_BITS];
      amp_a <= in_amp;
    end
  end

  // fold the full-wave index onto the quarter wave
  logic [SINE_INDEX_BITS-1:0] fold_idx;
  logic                       fold_neg;
  logic [QADDR_W-1:0]         rom_addr;

  always_comb begin
    if (idx_a <= QN) begin
      fold_idx = idx_a;
      fold_neg = 1'b0;
    end else if (idx_a <= HN) begin
      fold_idx = HN - idx_a;
      fold_neg = 1'b0;
    end else if (idx_a <= TQN) begin
      fold_idx = idx_a - HN;
      fold_neg = 1'b1;
    end else begin
      fold_idx = ~idx_a + 1'b1;   // full turn minus index
      fold_neg = 1'b1;
    end
    rom_addr = fold_idx[QADDR_W-1:0];
  end

  // stage B: ROM read
  logic [SINE_W-1:0]       sine_mag_b;
  logic                    neg_b;
  logic signed [AMP_W-1:0] amp_b;

  ssap_sine_rom u_rom (
    .clk     (clk),
    .rd_en   (load_b),
    .rd_addr (rom_addr),
    .rd_data (sine_mag_b)
  );

  always_ff @(posedge clk) begin
    if (load_b) begin
      neg_b <= fold_neg;
      amp_b <= amp_a;
    end
  end

  // stage C: signed product, Q2.30
  logic signed [SINE_W:0]    sine_b;
  logic signed [PROD_W-1:0]  prod_c;

  always_comb begin
    sine_b = neg_b ? -$signed({1'b0, sine_mag_b}) : $signed({1'b0, sine_mag_b});
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      prod_c <= PROD_W'(amp_b * sine_b);
    end
  end

  // stage D: round half up, drop fraction, saturate
  logic signed [PROD_W:0]     rounded;
  logic signed [SAMPLE_W-1:0] sample_d;

  always_comb begin
    rounded = ($signed({prod_c[PROD_W-1], prod_c}) + ROUND_HALF) >>> FRAC_BITS;
    if (rounded > SAT_MAX) begin
      sample_d = SAT_MAX[SAMPLE_W-1:0];
    end else if (rounded < SAT_MIN) begin
      sample_d = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sample_d = rounded[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      m_axis_tdata <= sample_d;
    end
  end

`ifndef SYNTHESIS
  // input only stalls when every stage holds a sample
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (v_a && v_b && v_c && m_axis_tvalid))
    else $error("input stalled with a free pipeline stage");

  // direct mode leaves the accumulator alone
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && direct_phase_mode) |=> $stable(phase_acc))
    else $error("accumulator moved in direct mode");

  // block start loads the step alone
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tuser && !direct_phase_mode) |=>
      (phase_acc == $past(in_step)))
    else $error("block start did not load the phase step");

  // folded address stays inside the quarter wave
  assert property (@(posedge clk) disable iff (rst)
    v_a |-> (fold_idx <= QN))
    else $error("quarter-wave address out of range");
`endif

endmodule
